/* rtl/kdlp_pkg.sv */
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types and constants for the key debounce and long press block.
// ----------------------------------------------------------------------------
package kdlp_pkg;

	localparam int NUM_KEYS = 7;
	localparam int CNT_W    = 16;
	localparam int DEB_W    = 8;
	localparam int MODE_W   = 2;
	localparam int IDX_W    = 2;
	localparam int CFG_W    = 16;
	localparam int IN_W     = 16;
	localparam int OUT_W    = 16;

	typedef logic [NUM_KEYS-1:0] keys_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [MODE_W-1:0]   mode_t;
	typedef logic [IDX_W-1:0]    cfg_idx_t;

	localparam keys_t BTN_TEMP     = keys_t'(7'h04);
	localparam keys_t BTN_STEAM    = keys_t'(7'h10);
	localparam keys_t BTN_HOTWATER = keys_t'(7'h20);
	localparam keys_t COMBO_CLEAN  = BTN_STEAM | BTN_HOTWATER;

	localparam mode_t MODE_IDLE  = 2'd0;
	localparam mode_t MODE_CLEAN = 2'd1;

	localparam cfg_idx_t REG_DEBOUNCE    = 2'd0;
	localparam cfg_idx_t REG_UNIT_TOGGLE = 2'd1;
	localparam cfg_idx_t REG_CLEAN_HOLD  = 2'd2;

	localparam logic [DEB_W-1:0] DEBOUNCE_RESET    = 8'd2;
	localparam cnt_t             UNIT_TOGGLE_RESET = 16'd300;
	localparam cnt_t             CLEAN_HOLD_RESET  = 16'd500;

	typedef struct packed {
		logic [DEB_W-1:0] debounce_ticks;
		cnt_t             unit_toggle_ticks;
		cnt_t             clean_hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic  activity;
		logic  unit_toggle;
		logic  clean_quit;
		logic  clean_start;
		keys_t short_key;
	} result_t;

endpackage

/* rtl/kdlp_cfg.sv */
// ----------------------------------------------------------------------------
// kdlp_cfg
// Configuration registers for the debounce and hold thresholds.
// ----------------------------------------------------------------------------
module kdlp_cfg
	import kdlp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks    <= DEBOUNCE_RESET;
			cfg_q.unit_toggle_ticks <= UNIT_TOGGLE_RESET;
			cfg_q.clean_hold_ticks  <= CLEAN_HOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE:    cfg_q.debounce_ticks    <= cfg_data[DEB_W-1:0];
				REG_UNIT_TOGGLE: cfg_q.unit_toggle_ticks <= cfg_data[CNT_W-1:0];
				REG_CLEAN_HOLD:  cfg_q.clean_hold_ticks  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/kdlp_core.sv */
// ----------------------------------------------------------------------------
// kdlp_core
// Accepted key map, shared hold counter and the per-tick decision logic.
// ----------------------------------------------------------------------------
module kdlp_core
	import kdlp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  keys_t   keys,
	input  mode_t   mode,
	input  cfg_t    cfg,
	output result_t res
);

	keys_t accepted_q;
	cnt_t  count_q;
	keys_t accepted_d;
	cnt_t  count_d;
	cnt_t  count_inc;
	logic  acc_one_hot;

	assign count_inc   = (count_q == '1) ? count_q : count_q + cnt_t'(1);
	assign acc_one_hot = (accepted_q != '0) && ((accepted_q & (accepted_q - keys_t'(1))) == '0);

	always_comb begin
		accepted_d = accepted_q;
		count_d    = count_q;
		res        = '0;
		if (keys == '0) begin
			// Only a single released key counts as a short press.
			if (acc_one_hot)
				res.short_key = accepted_q;
			accepted_d = '0;
			count_d    = '0;
		end else if (keys == accepted_q) begin
			res.activity = 1'b1;
			count_d      = count_inc;
			// The combo threshold takes priority; the temp check is made only below it.
			if (count_inc >= cfg.clean_hold_ticks) begin
				if (accepted_q == COMBO_CLEAN) begin
					if (mode == MODE_IDLE) begin
						count_d         = '0;
						res.clean_start = 1'b1;
					end else if (mode == MODE_CLEAN) begin
						count_d        = '0;
						res.clean_quit = 1'b1;
					end
				end
			end else if (count_inc >= cfg.unit_toggle_ticks) begin
				if (mode == MODE_IDLE && accepted_q == BTN_TEMP) begin
					count_d         = '0;
					res.unit_toggle = 1'b1;
				end
			end
		end else begin
			count_d = count_inc;
			if (count_inc >= cnt_t'(cfg.debounce_ticks)) begin
				res.activity = 1'b1;
				count_d      = '0;
				accepted_d   = keys;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_q <= '0;
			count_q    <= '0;
		end else if (adv) begin
			accepted_q <= accepted_d;
			count_q    <= count_d;
		end
	end

	a_events_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> $onehot0({res.clean_start, res.clean_quit, res.unit_toggle}))
		else $error("more than one hold event in one tick");

	a_short_one_hot: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> $onehot0(res.short_key))
		else $error("short press is not one-hot");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && keys == '0 |=> accepted_q == '0 && count_q == '0)
		else $error("release did not clear the key state");

	a_hold_event_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (res.clean_start || res.clean_quit || res.unit_toggle) |=> count_q == '0)
		else $error("hold event did not clear the counter");

	a_idle_state: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(accepted_q) && $stable(count_q))
		else $error("key state changed without an item");

endmodule

/* rtl/key_debounce_long_press_top.sv */
// ----------------------------------------------------------------------------
// key_debounce_long_press_top
// Key debounce with short press, unit toggle and cleaning combo detection.
// ----------------------------------------------------------------------------
// Throughput: one item per clock unless the output stalls on m_tready; the key state updates once per item.
// An input register and an output register part the two stream sides.
// Reset clears the accepted key map, the hold counter and both valid flags,
// and loads the thresholds with their default values.
module key_debounce_long_press_top
	import kdlp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // [6:0] key_bits, [8:7] device_mode
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // [6:0] short_key, [7] clean_start,
	                                    // [8] clean_quit, [9] unit_toggle, [10] activity
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic    valid_s1;
	keys_t   keys_s1;
	mode_t   mode_s1;
	logic    out_valid_q;
	result_t out_q;
	logic    adv;
	result_t res;
	cfg_t    cfg;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			keys_s1 <= s_tdata[NUM_KEYS-1:0];
			mode_s1 <= s_tdata[NUM_KEYS +: MODE_W];
		end
	end

	kdlp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kdlp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.keys   (keys_s1),
		.mode   (mode_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(out_q);

endmodule
